FILE: rtl/dmac_pkg.sv
package dmac_pkg;

  localparam int ADDR_WIDTH_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int BUS_AW    = 16;
  localparam int IN_DATA_W = 24;
  localparam int IN_USER_W = 2;
  localparam int OUT_DATA_W = 48;

  localparam logic [BUS_AW-1:0] A_GLOBAL = 16'h5070;
  localparam logic [BUS_AW-1:0] A_CTRL   = 16'h5093;
  localparam logic [BUS_AW-1:0] A_STATUS = 16'h5094;
  localparam logic [BUS_AW-1:0] A_COUNT  = 16'h5095;
  localparam logic [BUS_AW-1:0] A_DST_HI = 16'h5096;
  localparam logic [BUS_AW-1:0] A_DST_LO = 16'h5097;
  localparam logic [BUS_AW-1:0] A_SRC_HI = 16'h5099;
  localparam logic [BUS_AW-1:0] A_SRC_LO = 16'h509A;

  localparam logic [7:0] GLOBAL_RESET = 8'hFC;
  localparam logic [7:0] GLOBAL_WMASK = 8'hFD;
  localparam logic [7:0] STATUS_WMASK = 8'h38;

  localparam int CTRL_EN_BIT     = 0;
  localparam int CTRL_DST_UP_BIT = 5;
  localparam int CTRL_MEM_BIT    = 6;
  localparam int STAT_DONE_BIT   = 1;
  localparam int STAT_HALF_BIT   = 2;
  localparam int STAT_BUSY_BIT   = 7;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    CMD_RD_GLOBAL = 4'd0,
    CMD_RD_CTRL   = 4'd1,
    CMD_RD_STATUS = 4'd2,
    CMD_WR_GLOBAL = 4'd3,
    CMD_WR_CTRL   = 4'd4,
    CMD_WR_STATUS = 4'd5,
    CMD_WR_COUNT  = 4'd6,
    CMD_WR_DST_HI = 4'd7,
    CMD_WR_DST_LO = 4'd8,
    CMD_WR_SRC_HI = 4'd9,
    CMD_WR_SRC_LO = 4'd10,
    CMD_TICK      = 4'd11,
    CMD_ERROR     = 4'd12,
    CMD_NOP       = 4'd13
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic        transfer_done;
    logic [15:0] copy_destination;
    logic [15:0] copy_source;
    logic        copy_valid;
    logic        access_error;
    logic [7:0]  read_data;
  } res_t;

endpackage

FILE: rtl/dma_channel_memory_copy.sv
// DMA channel register bank with a byte-paced memory-to-memory copy engine.
// Each request is a bus read, a bus write or a tick, and gives exactly one
// response. One request is accepted every cycle while the response side keeps
// up; a request passes through the two-entry request queue and then the
// response register before its response appears. The decoder in front fills
// the queue, the register bank behind it executes one request per cycle while
// the response side keeps up, so throughput is set by that single execute
// stage. When the response side stalls, the queue absorbs up to two more
// requests before in_tready drops.
module dma_channel_memory_copy #(
  parameter int ADDR_WIDTH  = dmac_pkg::ADDR_WIDTH_DEF,
  parameter int QUEUE_DEPTH = dmac_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // address[15:0], write_data[23:16]
  input  logic [dmac_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode[1:0]
  input  logic [dmac_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // read_data[7:0], access_error[8], copy_valid[9], copy_source[25:10],
  // copy_destination[41:26], transfer_done[42], zero[47:43]
  output logic [dmac_pkg::OUT_DATA_W-1:0] out_tdata
);
  import dmac_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  req_t q_in;
  req_t q_out;

  dmac_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_req     (q_in)
  );

  dmac_fifo #(
    .Width ($bits(req_t)),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  dmac_back #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_req      (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: rtl/dmac_fifo.sv
module dmac_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [Width-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [Width-1:0] pop_data
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_r [Depth];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full     = (count_r == CW'(Depth));
  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/dmac_front.sv
module dmac_front (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dmac_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [dmac_pkg::IN_USER_W-1:0] in_tuser,
  input  logic                          q_full,
  output logic                          q_push,
  output dmac_pkg::req_t                q_req
);
  import dmac_pkg::*;

  logic [BUS_AW-1:0] addr;
  logic [7:0]        wdata;
  mode_t             mode;
  cmd_t              cmd;

  assign addr  = in_tdata[BUS_AW-1:0];
  assign wdata = in_tdata[BUS_AW+7:BUS_AW];
  assign mode  = mode_t'(in_tuser);

  always_comb begin
    cmd = CMD_NOP;
    unique case (mode)
      MODE_READ: begin
        cmd = CMD_ERROR;
        if (addr == A_GLOBAL) cmd = CMD_RD_GLOBAL;
        if (addr == A_CTRL)   cmd = CMD_RD_CTRL;
        if (addr == A_STATUS) cmd = CMD_RD_STATUS;
      end
      MODE_WRITE: begin
        cmd = CMD_ERROR;
        if (addr == A_GLOBAL) cmd = CMD_WR_GLOBAL;
        if (addr == A_CTRL)   cmd = CMD_WR_CTRL;
        if (addr == A_STATUS) cmd = CMD_WR_STATUS;
        if (addr == A_COUNT)  cmd = CMD_WR_COUNT;
        if (addr == A_DST_HI) cmd = CMD_WR_DST_HI;
        if (addr == A_DST_LO) cmd = CMD_WR_DST_LO;
        if (addr == A_SRC_HI) cmd = CMD_WR_SRC_HI;
        if (addr == A_SRC_LO) cmd = CMD_WR_SRC_LO;
      end
      MODE_TICK: cmd = CMD_TICK;
      MODE_NONE: cmd = CMD_NOP;
      default:   cmd = CMD_NOP;
    endcase
  end

  assign in_tready  = !q_full;
  assign q_push     = in_tvalid && !q_full;
  assign q_req.cmd  = cmd;
  assign q_req.data = wdata;

endmodule

FILE: rtl/dmac_back.sv
module dmac_back #(
  parameter int ADDR_WIDTH = dmac_pkg::ADDR_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  dmac_pkg::req_t                 q_req,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [dmac_pkg::OUT_DATA_W-1:0] out_tdata
);
  import dmac_pkg::*;

  logic [7:0]            glob_r, glob_nxt;
  logic [6:0]            ctrl_r, ctrl_nxt;
  logic [7:0]            stat_r, stat_nxt;
  logic [7:0]            count_r, count_nxt;
  logic [ADDR_WIDTH-1:0] src_r, src_nxt;
  logic [ADDR_WIDTH-1:0] dst_r, dst_nxt;
  logic                  valid_r, valid_nxt;
  res_t                  res_r, res_nxt;
  logic                  fire;
  logic                  active;
  logic [7:0]            d;

  assign fire   = q_valid && (!valid_r || out_tready);
  assign q_pop  = fire;
  assign d      = q_req.data;
  assign active = glob_r[0] && ctrl_r[CTRL_EN_BIT] && ctrl_r[CTRL_MEM_BIT];

  always_comb begin
    glob_nxt  = glob_r;
    ctrl_nxt  = ctrl_r;
    stat_nxt  = stat_r;
    count_nxt = count_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    valid_nxt = valid_r && !out_tready;
    res_nxt   = res_r;
    if (fire) begin
      valid_nxt = 1'b1;
      res_nxt   = '0;
      unique case (q_req.cmd)
        CMD_RD_GLOBAL: res_nxt.read_data = glob_r;
        CMD_RD_CTRL:   res_nxt.read_data = {1'b0, ctrl_r};
        CMD_RD_STATUS: res_nxt.read_data = stat_r;
        CMD_WR_GLOBAL: glob_nxt = (glob_r & ~GLOBAL_WMASK) | (d & GLOBAL_WMASK);
        CMD_WR_CTRL:   ctrl_nxt = d[6:0];
        CMD_WR_STATUS: begin
          stat_nxt = (stat_r & ~STATUS_WMASK) | (d & STATUS_WMASK);
          if (!d[STAT_DONE_BIT]) stat_nxt[STAT_DONE_BIT] = 1'b0;
          if (!d[STAT_HALF_BIT]) stat_nxt[STAT_HALF_BIT] = 1'b0;
        end
        CMD_WR_COUNT:  count_nxt = d;
        CMD_WR_DST_HI: dst_nxt[15:8] = d;
        CMD_WR_DST_LO: dst_nxt[7:0]  = d;
        CMD_WR_SRC_HI: src_nxt[15:8] = d;
        CMD_WR_SRC_LO: src_nxt[7:0]  = d;
        CMD_TICK: begin
          if (active) begin
            if (count_r != 8'd0) begin
              res_nxt.copy_valid       = 1'b1;
              res_nxt.copy_source      = src_r[15:0];
              res_nxt.copy_destination = dst_r[15:0];
              src_nxt   = src_r + 1'b1;
              dst_nxt   = ctrl_r[CTRL_DST_UP_BIT] ? dst_r + 1'b1 : dst_r - 1'b1;
              count_nxt = count_r - 8'd1;
            end else begin
              stat_nxt[STAT_DONE_BIT] = 1'b1;
              stat_nxt[STAT_BUSY_BIT] = 1'b0;
              res_nxt.transfer_done   = 1'b1;
            end
          end
        end
        CMD_ERROR:     res_nxt.access_error = 1'b1;
        CMD_NOP:       res_nxt = '0;
        default:       res_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glob_r  <= GLOBAL_RESET;
      ctrl_r  <= '0;
      stat_r  <= '0;
      count_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      glob_r  <= glob_nxt;
      ctrl_r  <= ctrl_nxt;
      stat_r  <= stat_nxt;
      count_r <= count_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r;

endmodule

FILE: rtl/dmac_checker.sv
module dmac_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dmac_pkg::OUT_DATA_W-1:0] out_tdata
);

  // no response straight out of reset
  assert property (@(posedge clk) (rst_n && $past(!rst_n)) |-> !out_tvalid)
    else $error("response valid right after reset");

  // stalled response holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled response changed");

  // error, copy and done are exclusive
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($countones({out_tdata[8], out_tdata[9], out_tdata[42]}) <= 1))
    else $error("more than one response kind set");

  // copy addresses only with a copy
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[9]) |-> (out_tdata[41:10] == 32'd0))
    else $error("copy address without copy");

  // error reads back zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[8]) |-> (out_tdata[7:0] == 8'd0 && out_tdata[47:43] == 5'd0))
    else $error("nonzero data on error response");

endmodule

bind dma_channel_memory_copy dmac_checker u_dmac_checker (.*);

FILE: bench/tb_top.sv
module tb_top;
  import dmac_pkg::*;

  localparam int ITEMS      = 1000;
  localparam int CYCLE_CAP  = 200000;
  localparam int DRAIN_WAIT = 10;
  localparam int HOLD_LEN   = 300;

  class copy_scoreboard;
    logic [7:0]  glob_ctl;
    logic [7:0]  chan_ctl;
    logic [7:0]  chan_stat;
    logic [7:0]  count;
    logic [15:0] src_ptr;
    logic [15:0] dst_ptr;
    res_t        pending[$];
    int          errors;

    function new();
      glob_ctl  = GLOBAL_RESET;
      chan_ctl  = 8'h00;
      chan_stat = 8'h00;
      count     = 8'h00;
      src_ptr   = 16'h0000;
      dst_ptr   = 16'h0000;
      errors    = 0;
    endfunction

    function void note_request(mode_t m, logic [15:0] a, logic [7:0] d);
      res_t       r;
      logic [7:0] s;
      r = '0;
      case (m)
        MODE_READ: begin
          case (a)
            A_GLOBAL: r.read_data = glob_ctl;
            A_CTRL:   r.read_data = chan_ctl;
            A_STATUS: r.read_data = chan_stat;
            default:  r.access_error = 1'b1;
          endcase
        end
        MODE_WRITE: begin
          case (a)
            A_GLOBAL: glob_ctl = (glob_ctl & ~GLOBAL_WMASK) | (d & GLOBAL_WMASK);
            A_CTRL:   chan_ctl = d & 8'h7F;
            A_STATUS: begin
              s = (chan_stat & ~STATUS_WMASK) | (d & STATUS_WMASK);
              if (!d[STAT_DONE_BIT]) s[STAT_DONE_BIT] = 1'b0;
              if (!d[STAT_HALF_BIT]) s[STAT_HALF_BIT] = 1'b0;
              chan_stat = s;
            end
            A_COUNT:  count = d;
            A_DST_HI: dst_ptr[15:8] = d;
            A_DST_LO: dst_ptr[7:0] = d;
            A_SRC_HI: src_ptr[15:8] = d;
            A_SRC_LO: src_ptr[7:0] = d;
            default:  r.access_error = 1'b1;
          endcase
        end
        MODE_TICK: begin
          if (glob_ctl[0] && chan_ctl[CTRL_EN_BIT] && chan_ctl[CTRL_MEM_BIT]) begin
            if (count != 8'h00) begin
              r.copy_valid       = 1'b1;
              r.copy_source      = src_ptr;
              r.copy_destination = dst_ptr;
              src_ptr = src_ptr + 16'd1;
              if (chan_ctl[CTRL_DST_UP_BIT]) dst_ptr = dst_ptr + 16'd1;
              else dst_ptr = dst_ptr - 16'd1;
              count = count - 8'd1;
            end else begin
              chan_stat[STAT_DONE_BIT] = 1'b1;
              chan_stat[STAT_BUSY_BIT] = 1'b0;
              r.transfer_done = 1'b1;
            end
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_response(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        report("response with no request pending");
      end else begin
        want = pending.pop_front();
        if (got.read_data !== want.read_data)
          report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
        if (got.access_error !== want.access_error)
          report($sformatf("access_error %b, want %b", got.access_error, want.access_error));
        if (got.copy_valid !== want.copy_valid)
          report($sformatf("copy_valid %b, want %b", got.copy_valid, want.copy_valid));
        if (got.copy_source !== want.copy_source)
          report($sformatf("copy_source %h, want %h", got.copy_source, want.copy_source));
        if (got.copy_destination !== want.copy_destination)
          report($sformatf("copy_destination %h, want %h",
                           got.copy_destination, want.copy_destination));
        if (got.transfer_done !== want.transfer_done)
          report($sformatf("transfer_done %b, want %b", got.transfer_done, want.transfer_done));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  copy_scoreboard sb = new();
  int             sent;
  int             burst_left;
  int             cycles;
  bit             hold_off_req;

  dma_channel_memory_copy DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("dma_channel_memory_copy verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_request(mode_t'(in_tuser), in_tdata[15:0], in_tdata[23:16]);
      if (out_tvalid && out_tready)
        sb.check_response(res_t'(out_tdata));
    end
  end

  // response side: ready rate redrawn whenever the phase counter wraps, one long hold-off on request
  initial begin
    int pct;
    int phase;
    pct = 100;
    phase = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      if (phase == 0) begin
        case ($urandom_range(0, 4))
          0, 1: pct = 100;
          2: pct = 75;
          3: pct = 40;
          default: pct = 10;
        endcase
      end
      phase = (phase + 1) % 50;
      out_tready <= ($urandom_range(1, 100) <= pct);
      @(negedge clk);
    end
  end

  task automatic send_req(input mode_t m, input logic [15:0] a, input logic [7:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {d, a};
    in_tuser  <= m;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] reg_addr(int i);
    case (i)
      0: return A_GLOBAL;
      1: return A_CTRL;
      2: return A_STATUS;
      3: return A_COUNT;
      4: return A_DST_HI;
      5: return A_DST_LO;
      6: return A_SRC_HI;
      7: return A_SRC_LO;
      8: return 16'h5098;
      default: return 16'h509B;
    endcase
  endfunction

  // pointer, count and enable setup, then enough ticks to finish and sometimes complete again
  task automatic copy_run();
    int         n;
    int         i;
    logic [7:0] ctl;
    logic [7:0] glob;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    ctl = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) != 0) ctl = ctl | 8'h41;
    glob = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) != 0) glob[0] = 1'b1;
    send_req(MODE_WRITE, A_SRC_HI, pick_byte());
    send_req(MODE_WRITE, A_SRC_LO, pick_byte());
    send_req(MODE_WRITE, A_DST_HI, pick_byte());
    send_req(MODE_WRITE, A_DST_LO, pick_byte());
    send_req(MODE_WRITE, A_COUNT, 8'(n));
    send_req(MODE_WRITE, A_CTRL, ctl);
    send_req(MODE_WRITE, A_GLOBAL, glob);
    for (i = 0; i < n + $urandom_range(1, 2); i++) begin
      send_req(MODE_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0)
        send_req(MODE_READ, reg_addr($urandom_range(0, 2)), 8'($urandom_range(0, 255)));
    end
    send_req(MODE_READ, A_STATUS, 8'($urandom_range(0, 255)));
    send_req(MODE_WRITE, A_STATUS, 8'($urandom_range(0, 255)));
  endtask

  task automatic noise_burst();
    int          n;
    logic [15:0] a;
    n = $urandom_range(1, 8);
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) a = 16'($urandom_range(0, 65535));
      else a = reg_addr($urandom_range(0, 9));
      send_req(mode_t'($urandom_range(0, 3)), a, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    bit hold_done;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = MODE_READ;
    out_tready   = 1'b0;
    sent         = 0;
    burst_left   = 0;
    cycles       = 0;
    hold_off_req = 1'b0;
    hold_done    = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values, write-only and unmapped requests, unused mode, idle tick, control write readback
    send_req(MODE_READ, A_GLOBAL, 8'h00);
    send_req(MODE_READ, A_CTRL, 8'hFF);
    send_req(MODE_READ, A_STATUS, 8'h00);
    send_req(MODE_READ, A_COUNT, 8'h00);
    send_req(MODE_READ, A_SRC_LO, 8'h00);
    send_req(MODE_WRITE, 16'h0000, 8'hFF);
    send_req(MODE_READ, 16'hFFFF, 8'hFF);
    send_req(MODE_NONE, A_GLOBAL, 8'hFF);
    send_req(MODE_TICK, 16'h0000, 8'h00);
    send_req(MODE_WRITE, A_GLOBAL, 8'hFF);
    send_req(MODE_WRITE, A_CTRL, 8'hFF);
    send_req(MODE_READ, A_CTRL, 8'h00);
    // pointers at the wrap points, destination counting down
    send_req(MODE_WRITE, A_CTRL, 8'h41);
    send_req(MODE_WRITE, A_SRC_HI, 8'hFF);
    send_req(MODE_WRITE, A_SRC_LO, 8'hFF);
    send_req(MODE_WRITE, A_DST_HI, 8'h00);
    send_req(MODE_WRITE, A_DST_LO, 8'h00);
    send_req(MODE_WRITE, A_COUNT, 8'h02);
    repeat (4) send_req(MODE_TICK, 16'hFFFF, 8'hFF);
    send_req(MODE_WRITE, A_STATUS, 8'hFF);
    send_req(MODE_READ, A_STATUS, 8'h00);
    send_req(MODE_WRITE, A_STATUS, 8'h00);
    send_req(MODE_WRITE, A_GLOBAL, 8'h00);

    while (sent < ITEMS) begin
      if (!hold_done && sent >= 300) begin
        hold_off_req = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) copy_run();
      else noise_burst();
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("dma_channel_memory_copy verification clean");
    end else begin
      $display("dma_channel_memory_copy verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dmac_pkg.sv
rtl/dmac_fifo.sv
rtl/dmac_front.sv
rtl/dmac_back.sv
rtl/dma_channel_memory_copy.sv
rtl/dmac_checker.sv
bench/tb_top.sv
